// File: design/binary_descriptor_ratio_matcher_core_defines.svh
// assertion macros for the descriptor ratio matcher
// expects clk_i and rst_ni in the scope of each use
`ifndef BINARY_DESCRIPTOR_RATIO_MATCHER_CORE_DEFINES_SVH
`define BINARY_DESCRIPTOR_RATIO_MATCHER_CORE_DEFINES_SVH

// same-cycle implication
`define BDRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdrm check failed");

// next-cycle implication
`define BDRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdrm check failed");

`endif

// File: design/bdrm_pkg.sv
// shared types, widths and constants of the descriptor ratio matcher
// no dependencies
`default_nettype none

package bdrm_pkg;

  localparam int unsigned DESC_BITS = 256;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NUM_WORDS = DESC_BITS / WORD_W;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ANGLE_W   = 13;
  localparam int unsigned IDX_W     = 11;
  localparam int unsigned DIST_W    = 9;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned POP_W     = 7;
  localparam int unsigned PROD_W    = 2 * CFG_W;

  localparam logic [DIST_W-1:0]  DIST_NONE   = DIST_W'(256);
  localparam logic [CNT_W-1:0]   COUNT_MAX   = CNT_W'(4095);
  localparam logic [ANGLE_W-1:0] ANGLE_FULL  = ANGLE_W'(5760);
  localparam logic [ANGLE_W-1:0] ANGLE_HALF  = ANGLE_W'(2880);
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = ANGLE_W'(480);

  localparam logic [CFG_W-1:0] RESET_RATIO  = CFG_W'(179);
  localparam logic [CFG_W-1:0] RESET_THRESH = CFG_W'(50);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CAND  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIENT = 2'd0,
    CFG_RATIO  = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + POP_W'(x[i]);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/bdrm_if.sv
// input and result channel interfaces of the descriptor ratio matcher
// depends on bdrm_pkg
`default_nettype none

interface bdrm_in_if import bdrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [WORD_W-1:0]  desc_word0;
  logic [WORD_W-1:0]  desc_word1;
  logic [WORD_W-1:0]  desc_word2;
  logic [WORD_W-1:0]  desc_word3;
  logic [ANGLE_W-1:0] keypoint_angle;
  logic [IDX_W-1:0]   keypoint_index;
  logic               usable;
  logic               last_item;

  modport source (
    output valid, command, desc_word0, desc_word1, desc_word2, desc_word3,
    output keypoint_angle, keypoint_index, usable, last_item,
    input  ready
  );

  modport sink (
    input  valid, command, desc_word0, desc_word1, desc_word2, desc_word3,
    input  keypoint_angle, keypoint_index, usable, last_item,
    output ready
  );
endinterface

interface bdrm_out_if import bdrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              match_found;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;
  logic [CNT_W-1:0]  match_total;

  modport source (
    output valid, match_found, best_index, best_distance, match_total,
    input  ready
  );

  modport sink (
    input  valid, match_found, best_index, best_distance, match_total,
    output ready
  );
endinterface

`default_nettype wire

// File: design/binary_descriptor_ratio_matcher_core.sv
// a result passes the stage 1, stage 2 and stage 3 registers into the output register
// throughput: one item per cycle while no clear or sweep is pending and the output
// is not stalled, set by the used-map ram read-modify-write and the tracker update
// a clear command blocks input until a sweep over all MAX_KEYPOINTS entries zeroes the map
// reset: async active low; the same sweep over all MAX_KEYPOINTS entries runs after reset
`default_nettype none
`include "binary_descriptor_ratio_matcher_core_defines.svh"

module binary_descriptor_ratio_matcher_core import bdrm_pkg::*; #(
  parameter int unsigned MAX_KEYPOINTS = 2048
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  bdrm_in_if.sink                   in_i,
  bdrm_out_if.source                out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_KEYPOINTS);
  localparam int unsigned EXT_W = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int unsigned SA_W  = ANGLE_W + 2;

  localparam logic [EXT_W-1:0]       KEY_LIMIT  = EXT_W'(MAX_KEYPOINTS);
  localparam logic [AW-1:0]          SWEEP_LAST = AW'(MAX_KEYPOINTS - 1);
  localparam logic signed [SA_W-1:0] FULL_S     = $signed(SA_W'(ANGLE_FULL));
  localparam logic signed [SA_W-1:0] HALF_S     = $signed(SA_W'(ANGLE_HALF));
  localparam logic signed [SA_W-1:0] LIMIT_S    = $signed(SA_W'(ANGLE_LIMIT));

  // configuration
  logic             orient_q;
  logic [CFG_W-1:0] ratio_q;
  logic [CFG_W-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 1'b1;
      ratio_q  <= RESET_RATIO;
      thresh_q <= RESET_THRESH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIENT: orient_q <= cfg_data_i[0];
        CFG_RATIO:  ratio_q  <= cfg_data_i;
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control
  logic           adv;
  logic           in_ready;
  logic           accept;
  logic           sweep_q;
  logic           clear_pend_q;
  logic [AW-1:0]  sweep_cnt_q;
  logic           sweep_done;

  // stage 1: ram data present
  logic                s1_valid_q;
  logic [CMD_W-1:0]    s1_cmd_q;
  logic [WORD_W-1:0]   s1_word_q [NUM_WORDS];
  logic [ANGLE_W-1:0]  s1_angle_q;
  logic [IDX_W-1:0]    s1_idx_q;
  logic                s1_usable_q;
  logic                s1_last_q;

  // query state
  logic [WORD_W-1:0]   qdesc_q [NUM_WORDS];
  logic [ANGLE_W-1:0]  qangle_q;
  logic                qlive_q;

  // stage 2: popcounts done
  logic                s2_valid_q;
  logic                s2_clear_q;
  logic                s2_query_q;
  logic                s2_score_q;
  logic                s2_dec_q;
  logic [IDX_W-1:0]    s2_idx_q;
  logic [POP_W-1:0]    s2_pop_q [NUM_WORDS];

  // trackers
  logic [DIST_W-1:0]   best_q;
  logic [DIST_W-1:0]   second_q;
  logic [IDX_W-1:0]    slot_q;
  logic                seen_q;

  // stage 3: decision
  logic                s3_valid_q;
  logic                s3_clear_q;
  logic                s3_dec_q;
  logic [DIST_W-1:0]   s3_best_q;
  logic [DIST_W-1:0]   s3_second_q;
  logic [IDX_W-1:0]    s3_slot_q;
  logic                s3_seen_q;

  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    cnt_d;

  logic                wlast_valid_q;
  logic [IDX_W-1:0]    wlast_idx_q;

  logic                out_valid_q;
  logic                out_found_q;
  logic [IDX_W-1:0]    out_index_q;
  logic [DIST_W-1:0]   out_dist_q;
  logic [CNT_W-1:0]    out_total_q;

  // ram
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic                ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic                ram_rdata;
  logic                dec_we;
  logic [EXT_W-1:0]    in_idx_ext;
  logic [EXT_W-1:0]    slot_ext;

  // decision
  logic                emit;
  logic                ok;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   best_sh;

  assign emit    = s3_valid_q && s3_dec_q;
  assign adv     = !(emit && out_valid_q && !out_o.ready);
  assign in_ready = adv && !clear_pend_q && !sweep_q;
  assign accept  = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign prod    = PROD_W'(ratio_q) * PROD_W'(s3_second_q);
  assign best_sh = PROD_W'({s3_best_q, 8'b0});
  assign ok      = emit && s3_seen_q && (s3_best_q <= thresh_q) && (prod >= best_sh);
  assign dec_we  = adv && ok;

  assign in_idx_ext = EXT_W'(in_i.keypoint_index);
  assign slot_ext   = EXT_W'(s3_slot_q);
  assign ram_raddr  = in_idx_ext[AW-1:0];
  assign ram_we     = sweep_q || dec_we;
  assign ram_waddr  = sweep_q ? sweep_cnt_q : slot_ext[AW-1:0];
  assign ram_wdata  = !sweep_q;
  assign sweep_done = sweep_q && (sweep_cnt_q == SWEEP_LAST);

  bdrm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_KEYPOINTS)
  ) u_used_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q       <= 1'b1;
      sweep_cnt_q   <= '0;
      clear_pend_q  <= 1'b0;
      wlast_valid_q <= 1'b0;
    end else begin
      if (accept && (in_i.command == CMD_CLEAR)) begin
        clear_pend_q <= 1'b1;
      end else if (sweep_done) begin
        clear_pend_q <= 1'b0;
      end
      if (adv && s3_valid_q && s3_clear_q) begin
        sweep_q     <= 1'b1;
        sweep_cnt_q <= '0;
      end else if (sweep_done) begin
        sweep_q <= 1'b0;
      end else if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + AW'(1);
      end
      if (sweep_q) begin
        wlast_valid_q <= 1'b0;
      end else if (dec_we) begin
        wlast_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_we) begin
      wlast_idx_q <= s3_slot_q;
    end
  end

  // stage 1 capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q     <= in_i.command;
      s1_word_q[0] <= in_i.desc_word0;
      s1_word_q[1] <= in_i.desc_word1;
      s1_word_q[2] <= in_i.desc_word2;
      s1_word_q[3] <= in_i.desc_word3;
      s1_angle_q   <= in_i.keypoint_angle;
      s1_idx_q     <= in_i.keypoint_index;
      s1_usable_q  <= in_i.usable;
      s1_last_q    <= in_i.last_item;
    end
  end

  // stage 1 logic: bitmap check, orientation, popcounts
  logic [ANGLE_W-1:0]     s1_angle_mod;
  logic signed [SA_W-1:0] diff_raw;
  logic signed [SA_W-1:0] diff_wrap;
  logic signed [SA_W-1:0] diff_abs;
  logic                   far;
  logic                   in_range;
  logic                   used;
  logic                   s1_score;
  logic [EXT_W-1:0]       s1_idx_ext;
  logic [POP_W-1:0]       s1_pop [NUM_WORDS];

  assign s1_angle_mod = (s1_angle_q >= ANGLE_FULL) ? (s1_angle_q - ANGLE_FULL) : s1_angle_q;
  assign diff_raw     = $signed(SA_W'(qangle_q)) - $signed(SA_W'(s1_angle_mod));

  always_comb begin
    priority if (diff_raw >= HALF_S) begin
      diff_wrap = diff_raw - FULL_S;
    end else if (diff_raw < -HALF_S) begin
      diff_wrap = diff_raw + FULL_S;
    end else begin
      diff_wrap = diff_raw;
    end
  end

  assign diff_abs   = (diff_wrap < 0) ? -diff_wrap : diff_wrap;
  assign far        = diff_abs > LIMIT_S;
  assign s1_idx_ext = EXT_W'(s1_idx_q);
  assign in_range   = s1_idx_ext < KEY_LIMIT;
  // marks still in flight or written on the read edge
  assign used       = ram_rdata || (ok && (s3_slot_q == s1_idx_q))
                      || (wlast_valid_q && (wlast_idx_q == s1_idx_q));
  assign s1_score   = (s1_cmd_q == CMD_CAND) && qlive_q && s1_usable_q && in_range
                      && !used && !(orient_q && far);

  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      s1_pop[w] = pop64(qdesc_q[w] ^ s1_word_q[w]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlive_q <= 1'b0;
    end else if (adv && s1_valid_q) begin
      unique case (s1_cmd_q)
        CMD_CLEAR: qlive_q <= 1'b0;
        CMD_QUERY: qlive_q <= s1_usable_q && !s1_last_q;
        CMD_CAND:  qlive_q <= qlive_q && !s1_last_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q && (s1_cmd_q == CMD_QUERY)) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        qdesc_q[w] <= s1_word_q[w];
      end
      qangle_q <= s1_angle_mod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_clear_q <= s1_cmd_q == CMD_CLEAR;
      s2_query_q <= s1_cmd_q == CMD_QUERY;
      s2_score_q <= s1_score;
      s2_dec_q   <= s1_last_q && ((s1_cmd_q == CMD_QUERY) || (s1_cmd_q == CMD_CAND));
      s2_idx_q   <= s1_idx_q;
      for (int w = 0; w < NUM_WORDS; w++) begin
        s2_pop_q[w] <= s1_pop[w];
      end
    end
  end

  // stage 2 logic: distance and tracker update
  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] best_d;
  logic [DIST_W-1:0] second_d;
  logic [IDX_W-1:0]  slot_d;
  logic              seen_d;

  assign cand_dist = DIST_W'(s2_pop_q[0]) + DIST_W'(s2_pop_q[1])
                   + DIST_W'(s2_pop_q[2]) + DIST_W'(s2_pop_q[3]);

  always_comb begin
    best_d   = best_q;
    second_d = second_q;
    slot_d   = slot_q;
    seen_d   = seen_q;
    if (s2_clear_q || s2_query_q) begin
      best_d   = DIST_NONE;
      second_d = DIST_NONE;
      slot_d   = '0;
      seen_d   = 1'b0;
    end else if (s2_score_q) begin
      if (cand_dist < best_q) begin
        second_d = best_q;
        best_d   = cand_dist;
        slot_d   = s2_idx_q;
        seen_d   = 1'b1;
      end else if (cand_dist < second_q) begin
        second_d = cand_dist;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= DIST_NONE;
      second_q   <= DIST_NONE;
      slot_q     <= '0;
      seen_q     <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        if (s2_dec_q) begin
          best_q   <= DIST_NONE;
          second_q <= DIST_NONE;
          slot_q   <= '0;
          seen_q   <= 1'b0;
        end else begin
          best_q   <= best_d;
          second_q <= second_d;
          slot_q   <= slot_d;
          seen_q   <= seen_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_clear_q  <= s2_clear_q;
      s3_dec_q    <= s2_dec_q;
      s3_best_q   <= best_d;
      s3_second_q <= second_d;
      s3_slot_q   <= slot_d;
      s3_seen_q   <= seen_d;
    end
  end

  // stage 3: count and result register
  assign cnt_d = (ok && (cnt_q != COUNT_MAX)) ? (cnt_q + CNT_W'(1)) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        if (s3_valid_q && s3_clear_q) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_d;
        end
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_found_q <= ok;
      out_index_q <= ok ? s3_slot_q : '0;
      out_dist_q  <= s3_best_q;
      out_total_q <= cnt_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.match_found   = out_found_q;
  assign out_o.best_index    = out_index_q;
  assign out_o.best_distance = out_dist_q;
  assign out_o.match_total   = out_total_q;

  `BDRM_ASSERT_IMP(a_sweep_blocks_input, sweep_q, !in_ready)
  `BDRM_ASSERT_IMP(a_no_mark_in_sweep, sweep_q, !dec_we)
  `BDRM_ASSERT_IMP(a_tracker_order, 1'b1, best_q <= second_q)
  `BDRM_ASSERT_IMP(a_seen_has_dist, seen_q, best_q != DIST_NONE)
  `BDRM_ASSERT_NEXT(a_count_grows, !(s3_valid_q && s3_clear_q), cnt_q >= $past(cnt_q))

endmodule

`default_nettype wire

// File: design/bdrm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bdrm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sim/binary_descriptor_ratio_matcher_core_tb.sv
// testbench for binary_descriptor_ratio_matcher_core: directed and random query/candidate
// streams checked beat by beat against a scoreboard that tracks the match state
// depends on bdrm_pkg, bdrm_if and the matcher core
`timescale 1ns / 1ps

module binary_descriptor_ratio_matcher_core_tb;
  import bdrm_pkg::*;

  localparam int unsigned MAX_KP       = 2048;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BEATS  = 280;
  localparam int unsigned NUM_PHASES   = 6;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]     command;
    logic [DESC_BITS-1:0] desc;
    logic [ANGLE_W-1:0]   angle;
    logic [IDX_W-1:0]     index;
    logic                 usable;
    logic                 last;
  } desc_beat_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  total;
  } decision_t;

  class match_scoreboard;
    bit                   orient_on;
    logic [CFG_W-1:0]     ratio;
    logic [CFG_W-1:0]     thresh;
    logic [DESC_BITS-1:0] q_desc;
    logic [ANGLE_W-1:0]   q_angle;
    bit                   q_live;
    int unsigned          best_d;
    int unsigned          second_d;
    logic [IDX_W-1:0]     best_idx;
    bit                   best_valid;
    bit                   used [MAX_KP];
    int unsigned          n_matched;
    decision_t            pending_decisions [$];
    int unsigned          errors;

    function new();
      orient_on = 1'b1;
      ratio     = RESET_RATIO;
      thresh    = RESET_THRESH;
      q_desc    = '0;
      q_angle   = '0;
      q_live    = 1'b0;
      reset_trackers();
      foreach (used[i]) used[i] = 1'b0;
      n_matched = 0;
      errors    = 0;
    endfunction

    function void reset_trackers();
      best_d     = DIST_NONE;
      second_d   = DIST_NONE;
      best_idx   = '0;
      best_valid = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ORIENT: orient_on = data[0];
        CFG_RATIO:  ratio = data;
        CFG_THRESH: thresh = data;
        default: ;
      endcase
    endfunction

    function bit angle_far(logic [ANGLE_W-1:0] a, logic [ANGLE_W-1:0] b);
      int d;
      d = int'(a % ANGLE_FULL) - int'(b % ANGLE_FULL);
      if (d >= int'(ANGLE_HALF)) d -= int'(ANGLE_FULL);
      else if (d < -int'(ANGLE_HALF)) d += int'(ANGLE_FULL);
      if (d < 0) d = -d;
      return d > int'(ANGLE_LIMIT);
    endfunction

    function void decide();
      decision_t r;
      bit ok;
      ok = q_live && best_valid && best_d <= thresh && ratio * second_d >= best_d * 256;
      if (ok) begin
        used[best_idx] = 1'b1;
        if (n_matched < COUNT_MAX) n_matched++;
      end
      r.found    = ok;
      r.index    = ok ? best_idx : '0;
      r.distance = DIST_W'(best_d);
      r.total    = CNT_W'(n_matched);
      pending_decisions.push_back(r);
      q_live = 1'b0;
      reset_trackers();
    endfunction

    function void take_beat(desc_beat_t b);
      int unsigned d;
      case (b.command)
        CMD_CLEAR: begin
          foreach (used[i]) used[i] = 1'b0;
          n_matched = 0;
          q_live = 1'b0;
          reset_trackers();
        end
        CMD_QUERY: begin
          q_desc  = b.desc;
          q_angle = b.angle;
          q_live  = b.usable;
          reset_trackers();
          if (b.last) decide();
        end
        CMD_CAND: begin
          if (q_live && b.usable && !used[b.index] &&
              !(orient_on && angle_far(q_angle, b.angle))) begin
            d = $countones(q_desc ^ b.desc);
            if (d < best_d) begin
              second_d   = best_d;
              best_d     = d;
              best_idx   = b.index;
              best_valid = 1'b1;
            end else if (d < second_d) begin
              second_d = d;
            end
          end
          if (b.last) decide();
        end
        default: ;
      endcase
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (pending_decisions.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: found=%0d idx=%0d dist=%0d total=%0d",
                   got.found, got.index, got.distance, got.total);
        return;
      end
      want = pending_decisions.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display({"result mismatch: want found=%0d idx=%0d dist=%0d total=%0d,",
                    " got %0d %0d %0d %0d"},
                   want.found, want.index, want.distance, want.total,
                   got.found, got.index, got.distance, got.total);
      end
    endfunction

    function int unsigned pending();
      return pending_decisions.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  bdrm_in_if  in_ch ();
  bdrm_out_if out_ch ();

  binary_descriptor_ratio_matcher_core #(
    .MAX_KEYPOINTS(MAX_KP)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  match_scoreboard sb = new();
  int unsigned     src_idle_pct;
  int unsigned     sink_idle_pct;
  int unsigned     beats_sent;
  int unsigned     stall_cycles;
  bit              took_beat;
  desc_beat_t      mon_beat;
  decision_t       mon_decision;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) out_ch.ready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      took_beat = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        mon_beat.command = in_ch.command;
        mon_beat.desc    = {in_ch.desc_word3, in_ch.desc_word2,
                            in_ch.desc_word1, in_ch.desc_word0};
        mon_beat.angle   = in_ch.keypoint_angle;
        mon_beat.index   = in_ch.keypoint_index;
        mon_beat.usable  = in_ch.usable;
        mon_beat.last    = in_ch.last_item;
        sb.take_beat(mon_beat);
        took_beat = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        mon_decision.found    = out_ch.match_found;
        mon_decision.index    = out_ch.best_index;
        mon_decision.distance = out_ch.best_distance;
        mon_decision.total    = out_ch.match_total;
        sb.check_decision(mon_decision);
        took_beat = 1'b1;
      end
      stall_cycles = took_beat ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("binary_descriptor_ratio_matcher_core_tb: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [DESC_BITS-1:0] rand_desc();
    logic [DESC_BITS-1:0] d;
    for (int i = 0; i < DESC_BITS / 32; i++) d[i*32 +: 32] = $urandom;
    return d;
  endfunction

  function automatic logic [DESC_BITS-1:0] near_desc(logic [DESC_BITS-1:0] q);
    logic [DESC_BITS-1:0] d;
    int unsigned k;
    int unsigned pick;
    d = q;
    pick = $urandom_range(99);
    if (pick < 3) return ~q;
    if (pick < 25) return rand_desc();
    k = (pick < 70) ? $urandom_range(40) : $urandom_range(120);
    repeat (k) d[$urandom_range(DESC_BITS-1)] ^= 1'b1;
    return d;
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    if ($urandom_range(9) == 0) return ANGLE_W'($urandom_range(8191, 5760));
    return ANGLE_W'($urandom_range(5759));
  endfunction

  function automatic logic [ANGLE_W-1:0] near_angle(logic [ANGLE_W-1:0] qa);
    int a;
    if ($urandom_range(9) < 3) return rand_angle();
    a = int'(qa) + int'($urandom_range(1100)) - 550;
    if (a < 0) a += int'(ANGLE_FULL);
    if (a > 8191) a -= int'(ANGLE_FULL);
    return ANGLE_W'(a);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(3) == 0) return IDX_W'($urandom_range(MAX_KP-1));
    return IDX_W'($urandom_range(255));
  endfunction

  function automatic desc_beat_t mk(logic [CMD_W-1:0] c, logic [DESC_BITS-1:0] d,
                                    logic [ANGLE_W-1:0] a, logic [IDX_W-1:0] i,
                                    bit u, bit l);
    desc_beat_t b;
    b.command = c;
    b.desc    = d;
    b.angle   = a;
    b.index   = i;
    b.usable  = u;
    b.last    = l;
    return b;
  endfunction

  task automatic push_beat(input desc_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= b.command;
    in_ch.desc_word0     <= b.desc[0*WORD_W +: WORD_W];
    in_ch.desc_word1     <= b.desc[1*WORD_W +: WORD_W];
    in_ch.desc_word2     <= b.desc[2*WORD_W +: WORD_W];
    in_ch.desc_word3     <= b.desc[3*WORD_W +: WORD_W];
    in_ch.keypoint_angle <= b.angle;
    in_ch.keypoint_index <= b.index;
    in_ch.usable         <= b.usable;
    in_ch.last_item      <= b.last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (b.command != CMD_UNKNOWN) beats_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input bit orient, input logic [CFG_W-1:0] ratio,
                               input logic [CFG_W-1:0] thresh);
    logic [CFG_W-2:0] hi;
    hi = (CFG_W-1)'($urandom_range(255));
    write_reg(CFG_ORIENT, {hi, orient});
    write_reg(CFG_RATIO, ratio);
    write_reg(CFG_THRESH, thresh);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // a decision beat flushes everything queued ahead of it
  task automatic settle();
    push_beat(mk(CMD_QUERY, rand_desc(), rand_angle(), pick_index(), 1'b0, 1'b1));
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n);
    logic [DESC_BITS-1:0] q;
    logic [ANGLE_W-1:0]   qa;
    logic [CMD_W-1:0]     cmd;
    int unsigned          ncand;
    int unsigned          pick;
    int unsigned          start;
    start = beats_sent;
    while (beats_sent - start < n) begin
      if ($urandom_range(99) < 85) begin
        q  = rand_desc();
        qa = rand_angle();
        ncand = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
        push_beat(mk(CMD_QUERY, q, qa, pick_index(), $urandom_range(9) != 0, ncand == 0));
        for (int i = 1; i <= ncand; i++)
          push_beat(mk(CMD_CAND, near_desc(q), near_angle(qa), pick_index(),
                       $urandom_range(9) != 0, i == ncand && $urandom_range(19) != 0));
      end else begin
        pick = $urandom_range(99);
        if (pick < 25) cmd = CMD_CLEAR;
        else if (pick < 35) cmd = CMD_UNKNOWN;
        else cmd = CMD_W'($urandom_range(2, 1));
        push_beat(mk(cmd, rand_desc(), rand_angle(), IDX_W'($urandom_range(MAX_KP-1)),
                     $urandom_range(1) != 0, $urandom_range(1) != 0));
      end
    end
  endtask

  task automatic run_directed();
    logic [DESC_BITS-1:0] q;
    logic [DESC_BITS-1:0] two_off;
    logic [DESC_BITS-1:0] one_hot;
    q = rand_desc();
    two_off = q ^ {1'b1, {(DESC_BITS-2){1'b0}}, 1'b1};
    one_hot = {{(DESC_BITS-1){1'b0}}, 1'b1};
    push_beat(mk(CMD_CLEAR, '0, '0, '0, 1'b0, 1'b0));
    push_beat(mk(CMD_UNKNOWN, q, '0, '0, 1'b1, 1'b1));
    // query without a live landmark
    push_beat(mk(CMD_QUERY, q, '0, '0, 1'b0, 1'b1));
    push_beat(mk(CMD_QUERY, q, 13'd5759, '0, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, ~q, 13'd0, 11'd2047, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd8191, 11'd5, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd5759, 11'd7, 1'b0, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd5279, 11'd9, 1'b1, 1'b1));
    // slot already taken
    push_beat(mk(CMD_QUERY, q, 13'd5759, '0, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd5759, 11'd9, 1'b1, 1'b1));
    // wrapped angles and a tie on the ratio bound
    push_beat(mk(CMD_QUERY, q, 13'd0, '0, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, two_off, 13'd5760, 11'd100, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd481, 11'd101, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, two_off, 13'd480, 11'd102, 1'b1, 1'b1));
    // stray candidate after the decision
    push_beat(mk(CMD_CAND, q, 13'd0, 11'd200, 1'b1, 1'b1));
    push_beat(mk(CMD_QUERY, q, 13'd0, '0, 1'b1, 1'b1));
    push_beat(mk(CMD_QUERY, '1, 13'd0, '0, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, '0, 13'd0, 11'd2047, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, one_hot, 13'd0, 11'd2046, 1'b1, 1'b1));
    push_beat(mk(CMD_CLEAR, q, 13'd0, '0, 1'b1, 1'b1));
    push_beat(mk(CMD_QUERY, q, 13'd100, '0, 1'b1, 1'b0));
    push_beat(mk(CMD_CAND, q, 13'd100, 11'd9, 1'b1, 1'b1));
  endtask

  initial begin
    bit          set_orient [NUM_PHASES];
    int unsigned set_ratio  [NUM_PHASES];
    int unsigned set_thresh [NUM_PHASES];
    set_orient           = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    set_ratio            = '{179, 256, 0, 300, 128, 220};
    set_thresh           = '{50, 256, 0, 511, 80, 120};
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.command        = '0;
    in_ch.desc_word0     = '0;
    in_ch.desc_word1     = '0;
    in_ch.desc_word2     = '0;
    in_ch.desc_word3     = '0;
    in_ch.keypoint_angle = '0;
    in_ch.keypoint_index = '0;
    in_ch.usable         = 1'b0;
    in_ch.last_item      = 1'b0;
    out_ch.ready         = 1'b0;
    src_idle_pct         = 38;
    sink_idle_pct        = 71;
    beats_sent           = 0;
    stall_cycles         = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    apply_setting(1'b1, 9'd256, 9'd256);
    run_directed();
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        src_idle_pct  = 38;
        sink_idle_pct = 71;
      end else if (p < 4) begin
        src_idle_pct  = 71;
        sink_idle_pct = 38;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      apply_setting(set_orient[p], CFG_W'(set_ratio[p]), CFG_W'(set_thresh[p]));
      run_random(PHASE_BEATS);
      settle();
    end

    if (sb.errors == 0) begin
      $display("binary_descriptor_ratio_matcher_core_tb: PASS");
    end else begin
      $display("binary_descriptor_ratio_matcher_core_tb: FAIL");
    end
    $finish;
  end

endmodule
